// ===== rtl/acc_int_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acc_int_pkg
// Shared types, register codes and saturation helpers for the trapezoidal
// accelerometer integrator.
// ----------------------------------------------------------------------------
package acc_int_pkg;

  // Register indexes (byte address 4*index)
  localparam logic [1:0] REG_STEP_TIME     = 2'd0;
  localparam logic [1:0] REG_ACCEL_GAIN    = 2'd1;
  localparam logic [1:0] REG_TAP_THRESHOLD = 2'd2;

  // Register reset values and legal dt range
  localparam logic [16:0] STEP_TIME_RST     = 17'd6554;
  localparam logic [23:0] ACCEL_GAIN_RST    = 24'd10045;
  localparam logic [23:0] TAP_THRESHOLD_RST = 24'd65536;
  localparam logic [16:0] STEP_MIN          = 17'd7;
  localparam logic [16:0] STEP_MAX          = 17'd65536;

  // Input request: action plus three raw samples
  typedef struct packed {
    logic               action;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } in_item_t;

  // Result: velocity and displacement per axis, tap flag
  typedef struct packed {
    logic signed [39:0] vel_x;
    logic signed [39:0] vel_y;
    logic signed [39:0] vel_z;
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] pos_z;
    logic               tap_seen;
  } out_item_t;

  // Clamp a 32-bit value to the signed 24-bit range
  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Clamp a 43-bit value to the signed 40-bit range
  function automatic logic signed [39:0] sat40(input logic signed [42:0] v);
    logic signed [39:0] r;
    if (v > 43'sd549755813887) begin
      r = 40'sh7FFFFFFFFF;
    end else if (v < -43'sd549755813888) begin
      r = 40'sh8000000000;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/accel_trapezoid_integrator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// accel_trapezoid_integrator_top
// Scales raw accelerometer samples to Q8.16 m/s^2 and integrates them twice
// per axis by the trapezoidal rule, with saturation and Z-axis tap detection.
// ----------------------------------------------------------------------------
// One 25x24-bit multiplier, followed by a product register, is shared by all
// steps and axes under a small sequencer. A sample request runs nine
// multiplier/accumulate steps per axis (scale, dt times summed acceleration,
// two half products of dt times summed velocity, and the rounding, saturation
// and write-back steps between them); a reset-reference request runs only the
// scale and write-back steps per axis. in_ready is high only while the
// sequencer is idle. A finished result sits in an output register, so the next
// request can be taken while the result waits on out_ready. Registers (APB,
// 4-byte stride): 0 step_time (writes whose low 17 bits lie outside 7..65536
// are dropped), 1 accel_gain, 2 tap_threshold.
// ----------------------------------------------------------------------------
module accel_trapezoid_integrator_top #(
  parameter int AXES = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire acc_int_pkg::in_item_t   in_data,
  // output channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output acc_int_pkg::out_item_t       out_data,
  // configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [3:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import acc_int_pkg::*;

  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

  // Sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_A  = 4'd1;
  localparam logic [3:0] ST_ACC    = 4'd2;
  localparam logic [3:0] ST_MUL_V  = 4'd3;
  localparam logic [3:0] ST_VEL    = 4'd4;
  localparam logic [3:0] ST_SUM    = 4'd5;
  localparam logic [3:0] ST_MUL_LO = 4'd6;
  localparam logic [3:0] ST_MUL_HI = 4'd7;
  localparam logic [3:0] ST_POS1   = 4'd8;
  localparam logic [3:0] ST_POS2   = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  // Configuration registers
  logic [16:0] step_time;
  logic [23:0] accel_gain;
  logic [23:0] tap_threshold;

  // Integrator state
  logic signed [23:0] prev_accel   [AXES];
  logic signed [39:0] velocity     [AXES];
  logic signed [39:0] displacement [AXES];

  // Sequencer and datapath registers
  logic [3:0]         state;
  logic [AXIS_W-1:0]  axis;
  in_item_t           in_q;
  logic               tap;
  logic signed [48:0] prod;
  logic signed [23:0] cur_acc;
  logic signed [39:0] vnew;
  logic signed [40:0] vsum;
  logic [37:0]        lo_prod;
  logic signed [58:0] full;
  out_item_t          out_q;

  // Combinational datapath
  logic signed [24:0] mul_a;
  logic [23:0]        mul_b;
  logic signed [49:0] mul_full;
  logic signed [15:0] raw_sel;
  logic signed [23:0] prev_sel;
  logic signed [39:0] vel_sel;
  logic signed [39:0] disp_sel;
  logic signed [39:0] acc_rnd;
  logic signed [23:0] acc_sat;
  logic signed [24:0] acc_sum;
  logic signed [24:0] tap_diff;
  logic [24:0]        tap_mag;
  logic signed [41:0] vel_rnd;
  logic signed [42:0] vel_new;
  logic signed [58:0] pos_rnd;
  logic signed [42:0] pos_new;
  logic               last_axis;
  logic               tap_axis;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic signed [39:0] vel_view [3];
  logic signed [39:0] pos_view [3];

  assign pready   = 1'b1;
  assign in_ready = (state == ST_IDLE);
  assign out_data = out_q;

  // Register file write and read
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time     <= STEP_TIME_RST;
      accel_gain    <= ACCEL_GAIN_RST;
      tap_threshold <= TAP_THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STEP_TIME: begin
          if (pwdata[16:0] >= STEP_MIN && pwdata[16:0] <= STEP_MAX) begin
            step_time <= pwdata[16:0];
          end
        end
        REG_ACCEL_GAIN:    accel_gain    <= pwdata[23:0];
        REG_TAP_THRESHOLD: tap_threshold <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STEP_TIME:     prdata = {15'd0, step_time};
      REG_ACCEL_GAIN:    prdata = {8'd0, accel_gain};
      REG_TAP_THRESHOLD: prdata = {8'd0, tap_threshold};
      default:           prdata = 32'd0;
    endcase
  end

  // Per-axis operand selection
  always_comb begin
    if (axis == AXIS_W'(0)) begin
      raw_sel = in_q.raw_x;
    end else if (axis == AXIS_W'(1)) begin
      raw_sel = in_q.raw_y;
    end else begin
      raw_sel = in_q.raw_z;
    end
  end

  assign prev_sel  = prev_accel[axis];
  assign vel_sel   = velocity[axis];
  assign disp_sel  = displacement[axis];
  assign last_axis = (axis == AXIS_W'(AXES - 1));
  assign tap_axis  = (AXES >= 3) && last_axis;

  // Shared multiplier operand mux
  assign acc_sum = {cur_acc[23], cur_acc} + {prev_sel[23], prev_sel};

  always_comb begin
    case (state)
      ST_MUL_A: begin
        mul_a = {{9{raw_sel[15]}}, raw_sel};
        mul_b = accel_gain;
      end
      ST_MUL_V: begin
        mul_a = acc_sum;
        mul_b = {7'd0, step_time};
      end
      ST_MUL_LO: begin
        mul_a = {4'd0, vsum[20:0]};
        mul_b = {7'd0, step_time};
      end
      ST_MUL_HI: begin
        mul_a = {{5{vsum[40]}}, vsum[40:21]};
        mul_b = {7'd0, step_time};
      end
      default: begin
        mul_a = 25'sd0;
        mul_b = 24'd0;
      end
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // Scale: round half up at bit 8, clamp to Q8.16
  assign acc_rnd = prod[39:0] + 40'sd128;
  assign acc_sat = sat24($signed(acc_rnd[39:8]));

  // Tap: |prev_z - cur_z| against threshold
  assign tap_diff = {prev_sel[23], prev_sel} - {cur_acc[23], cur_acc};
  assign tap_mag  = tap_diff[24] ? 25'(-tap_diff) : tap_diff;

  // Velocity update
  assign vel_rnd = prod[41:0] + 42'sd65536;
  assign vel_new = {{3{vel_sel[39]}}, vel_sel} + {{18{vel_rnd[41]}}, vel_rnd[41:17]};

  // Displacement update
  assign pos_rnd = full + 59'sd65536;
  assign pos_new = {{3{disp_sel[39]}}, disp_sel} + {pos_rnd[58], pos_rnd[58:17]};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= '0;
      tap       <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        prev_accel[i]   <= '0;
        velocity[i]     <= '0;
        displacement[i] <= '0;
      end
    end else begin
      // Result handshake: load when the output register is free
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            axis  <= '0;
            tap   <= 1'b0;
            state <= ST_MUL_A;
          end
        end
        ST_MUL_A: state <= ST_ACC;
        ST_ACC: begin
          if (in_q.action) begin
            prev_accel[axis]   <= acc_sat;
            velocity[axis]     <= '0;
            displacement[axis] <= '0;
            if (last_axis) begin
              state <= ST_DONE;
            end else begin
              axis  <= axis + AXIS_W'(1);
              state <= ST_MUL_A;
            end
          end else begin
            state <= ST_MUL_V;
          end
        end
        ST_MUL_V: begin
          if (tap_axis && (tap_mag > {1'b0, tap_threshold})) begin
            tap <= 1'b1;
          end
          prev_accel[axis] <= cur_acc;
          state            <= ST_VEL;
        end
        ST_VEL: state <= ST_SUM;
        ST_SUM: begin
          velocity[axis] <= vnew;
          state          <= ST_MUL_LO;
        end
        ST_MUL_LO: state <= ST_MUL_HI;
        ST_MUL_HI: state <= ST_POS1;
        ST_POS1:   state <= ST_POS2;
        ST_POS2: begin
          displacement[axis] <= sat40(pos_new);
          if (last_axis) begin
            state <= ST_DONE;
          end else begin
            axis  <= axis + AXIS_W'(1);
            state <= ST_MUL_A;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Views of the state for the result, zero for absent axes
  for (genvar k = 0; k < 3; k++) begin : g_view
    if (k < AXES) begin : g_on
      assign vel_view[k] = velocity[k];
      assign pos_view[k] = displacement[k];
    end else begin : g_off
      assign vel_view[k] = 40'sd0;
      assign pos_view[k] = 40'sd0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_full[48:0];
    if (state == ST_IDLE && in_valid) begin
      in_q <= in_data;
    end
    if (state == ST_ACC) begin
      cur_acc <= acc_sat;
    end
    if (state == ST_VEL) begin
      vnew <= sat40(vel_new);
    end
    if (state == ST_SUM) begin
      vsum <= {vel_sel[39], vel_sel} + {vnew[39], vnew};
    end
    if (state == ST_MUL_HI) begin
      lo_prod <= prod[37:0];
    end
    // high half product keeps its sign bit into the 59-bit sum
    if (state == ST_POS1) begin
      full <= {prod[37:0], 21'd0} + {21'd0, lo_prod};
    end
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_q.vel_x    <= vel_view[0];
      out_q.vel_y    <= vel_view[1];
      out_q.vel_z    <= vel_view[2];
      out_q.pos_x    <= pos_view[0];
      out_q.pos_y    <= pos_view[1];
      out_q.pos_z    <= pos_view[2];
      out_q.tap_seen <= tap;
    end
  end

  // Checks
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    axis <= AXIS_W'(AXES - 1))
    else $error("axis counter out of range");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_time >= STEP_MIN && step_time <= STEP_MAX)
    else $error("step_time outside legal range");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside done step");

  a_reset_no_tap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && in_q.action) |-> !tap)
    else $error("tap flagged on reset request");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trapezoidal accelerometer integrator. Sample and
// re-reference requests go in over valid/ready with random idle bursts on both
// sides. A fixed-point integrator kept here predicts each result, and every
// result is compared field by field. APB writes step the block through several
// dt, gain and tap-threshold settings, extremes included, with read-back.
// ----------------------------------------------------------------------------
module tb_top;
  import acc_int_pkg::*;

  localparam int AXES = 3;
  localparam logic ACT_INTEGRATE = 1'b0;
  localparam logic ACT_REREF     = 1'b1;
  localparam logic [1:0] REG_SPARE = 2'd3;  // decodes to no register
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_STALL   = 300;
  localparam int DRAIN_CYCLES = 60;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  accel_trapezoid_integrator_top #(.AXES(AXES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the registers and of the integrator state
  logic [16:0] step_shadow = STEP_TIME_RST;
  logic [23:0] gain_shadow = ACCEL_GAIN_RST;
  logic [23:0] thr_shadow  = TAP_THRESHOLD_RST;
  longint      prev_acc[3] = '{0, 0, 0};
  longint      vel_acc[3]  = '{0, 0, 0};
  longint      pos_acc[3]  = '{0, 0, 0};

  in_item_t  sample_queue[$];   // requests not yet offered
  out_item_t motion_queue[$];   // predicted results, oldest first

  int n_errors    = 0;
  int quiet       = 0;
  int idle_pct    = 0;
  int in_gap      = 0;
  int ready_gap   = 0;
  int stall_left  = 0;
  bit stall_armed = 1'b0;
  bit stall_done  = 1'b0;

  function automatic longint clamp_bits(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // add half an LSB, then floor
  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Register write as the block should take it
  function automatic void shadow_write(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_STEP_TIME: begin
        if (val[16:0] >= STEP_MIN && val[16:0] <= STEP_MAX) step_shadow = val[16:0];
      end
      REG_ACCEL_GAIN:    gain_shadow = val[23:0];
      REG_TAP_THRESHOLD: thr_shadow = val[23:0];
      default: ;
    endcase
  endfunction

  // Scale, integrate twice and detect taps for one request
  function automatic out_item_t integrate_sample(in_item_t req);
    logic signed [15:0] raw[3];
    longint acc_now[3];
    longint vel_out[3];
    longint pos_out[3];
    longint dt;
    longint nv;
    longint nd;
    longint dz;
    out_item_t res;
    int i;
    raw[0] = req.raw_x;
    raw[1] = req.raw_y;
    raw[2] = req.raw_z;
    dt = longint'(step_shadow);
    res = '0;
    for (i = 0; i < 3; i++) begin
      acc_now[i] = 0;
      vel_out[i] = 0;
      pos_out[i] = 0;
    end
    for (i = 0; i < AXES; i++) begin
      acc_now[i] = clamp_bits(round_shr(longint'(raw[i]) * longint'(gain_shadow), 8), 24);
    end
    if (req.action == ACT_REREF) begin
      // new reference: clear motion, capture sample, all-zero result
      for (i = 0; i < 3; i++) begin
        vel_acc[i] = 0;
        pos_acc[i] = 0;
        prev_acc[i] = acc_now[i];
      end
    end else begin
      dz = prev_acc[2] - acc_now[2];
      if (dz < 0) dz = -dz;
      if (AXES >= 3 && dz > longint'(thr_shadow)) res.tap_seen = 1'b1;
      for (i = 0; i < AXES; i++) begin
        nv = clamp_bits(vel_acc[i] + round_shr(dt * (acc_now[i] + prev_acc[i]), 17), 40);
        nd = clamp_bits(pos_acc[i] + round_shr(dt * (vel_acc[i] + nv), 17), 40);
        vel_acc[i] = nv;
        pos_acc[i] = nd;
        prev_acc[i] = acc_now[i];
        vel_out[i] = nv;
        pos_out[i] = nd;
      end
    end
    res.vel_x = vel_out[0][39:0];
    res.vel_y = vel_out[1][39:0];
    res.vel_z = vel_out[2][39:0];
    res.pos_x = pos_out[0][39:0];
    res.pos_y = pos_out[1][39:0];
    res.pos_z = pos_out[2][39:0];
    return res;
  endfunction

  task automatic note_error(string what, longint want, longint got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic compare_field(string name, logic signed [39:0] want,
                               logic signed [39:0] got);
    if (want !== got) note_error(name, want, got);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (motion_queue.size() == 0) begin
      note_error("result with nothing pending", 0, 0);
      return;
    end
    want = motion_queue.pop_front();
    compare_field("vel_x", want.vel_x, got.vel_x);
    compare_field("vel_y", want.vel_y, got.vel_y);
    compare_field("vel_z", want.vel_z, got.vel_z);
    compare_field("pos_x", want.pos_x, got.pos_x);
    compare_field("pos_y", want.pos_y, got.pos_y);
    compare_field("pos_z", want.pos_z, got.pos_z);
    compare_field("tap_seen", 40'(want.tap_seen), 40'(got.tap_seen));
  endtask

  // Request driver: predicts on accept, then offers the next queued request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) motion_queue.push_back(integrate_sample(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_data <= sample_queue.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(99) < idle_pct) in_gap = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_gap = 0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (stall_armed && !stall_done) begin
        stall_left = LONG_STALL;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99) < idle_pct) ready_gap = $urandom_range(1, 7);
      end
    end
  end

  // Watchdog: cycles with no transfer on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_write(idx, val);
  endtask

  task automatic reg_readback(logic [1:0] idx);
    logic [31:0] want;
    logic [31:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_STEP_TIME:     want = 32'(step_shadow);
      REG_ACCEL_GAIN:    want = 32'(gain_shadow);
      REG_TAP_THRESHOLD: want = 32'(thr_shadow);
      default:           want = '0;
    endcase
    if (got !== want) note_error("register read", want, got);
  endtask

  task automatic readback_all();
    reg_readback(REG_STEP_TIME);
    reg_readback(REG_ACCEL_GAIN);
    reg_readback(REG_TAP_THRESHOLD);
  endtask

  // Block is idle once everything queued was taken and has come back;
  // sampled mid-cycle so the driver's updates at the edge are settled
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || motion_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void push_req(logic act, logic signed [15:0] x,
                                   logic signed [15:0] y, logic signed [15:0] z);
    in_item_t item;
    item.action = act;
    item.raw_x = x;
    item.raw_y = y;
    item.raw_z = z;
    sample_queue.push_back(item);
  endfunction

  function automatic logic signed [15:0] rand_raw();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'(int'($urandom_range(0, 400)) - 200);
      4:       return 16'(int'($urandom_range(0, 8000)) - 4000);
      default: return 16'($urandom);
    endcase
  endfunction

  // integrate runs with random content and occasional re-references
  function automatic void push_random(int n, int reref_pct);
    repeat (n) begin
      if ($urandom_range(99) < reref_pct) begin
        push_req(ACT_REREF, rand_raw(), rand_raw(), rand_raw());
      end else begin
        push_req(ACT_INTEGRATE, rand_raw(), rand_raw(), rand_raw());
      end
    end
  endfunction

  // X pinned high and Y pinned low so displacement runs into its limits
  function automatic void push_strong(int n);
    repeat (n) begin
      push_req(ACT_INTEGRATE, 16'($urandom_range(129, 32767)),
               16'(-int'($urandom_range(129, 32768))), rand_raw());
    end
  endfunction

  // Stimulus phases
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;
    readback_all();

    // reset settings: extremes, bit patterns, re-reference with a capture
    push_req(ACT_REREF, 16'sh0000, 16'sh0000, 16'sh0000);
    push_req(ACT_INTEGRATE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_req(ACT_INTEGRATE, 16'sh8000, 16'sh8000, 16'sh8000);
    push_req(ACT_INTEGRATE, 16'sh0000, 16'sh0000, 16'sh0000);
    push_req(ACT_INTEGRATE, 16'sh5555, 16'shAAAA, 16'sh5555);
    push_req(ACT_INTEGRATE, 16'shAAAA, 16'sh5555, 16'shAAAA);
    push_req(ACT_REREF, 16'sh1234, 16'shEDCC, 16'sh4321);
    push_req(ACT_INTEGRATE, 16'sh1234, 16'shEDCC, 16'sh4321);
    push_req(ACT_INTEGRATE, 16'shFFFF, 16'sh0001, 16'sh7FFF);
    wait_idle();

    // unity scaling, shortest dt; tap exactly at and just over the threshold
    apb_write(REG_ACCEL_GAIN, 32'h0000_0100);
    apb_write(REG_TAP_THRESHOLD, 32'd100);
    apb_write(REG_STEP_TIME, 32'd7);
    apb_write(REG_STEP_TIME, 32'd6);       // below range, dropped
    apb_write(REG_STEP_TIME, 32'd0);
    apb_write(REG_STEP_TIME, 32'd65537);   // above range, dropped
    apb_write(REG_SPARE, 32'hFFFF_FFFF);   // no register there
    readback_all();
    push_req(ACT_REREF, 16'sh0000, 16'sh0000, 16'sh0000);
    push_req(ACT_INTEGRATE, 16'sh0000, 16'sh0000, 16'sd100);
    push_req(ACT_INTEGRATE, 16'sh0000, 16'sh0000, -16'sd1);
    push_req(ACT_INTEGRATE, 16'sh0001, 16'shFFFF, -16'sd1);
    push_req(ACT_INTEGRATE, 16'sh7FFF, 16'sh8000, -16'sd102);
    wait_idle();

    // largest gain and dt: scaled accel clips, displacement saturates
    apb_write(REG_STEP_TIME, 32'd65536);
    apb_write(REG_ACCEL_GAIN, 32'h00FF_FFFF);
    apb_write(REG_TAP_THRESHOLD, 32'd0);
    readback_all();
    push_req(ACT_REREF, 16'sh7FFF, 16'sh8000, 16'sh0000);
    push_req(ACT_INTEGRATE, 16'sh7FFF, 16'sh8000, 16'sh0001);
    push_req(ACT_INTEGRATE, 16'sh7FFF, 16'sh8000, 16'sh0001);
    idle_pct = 30;
    push_strong(380);
    wait_idle();

    // random settings; bits above a register's width are dropped
    apb_write(REG_STEP_TIME, 32'hFFFE_03E8);
    apb_write(REG_STEP_TIME, 32'($urandom_range(7, 65536)));
    apb_write(REG_ACCEL_GAIN, {8'hA5, 24'($urandom_range(4000, 40000))});
    apb_write(REG_TAP_THRESHOLD, {8'h5A, 24'($urandom_range(0, 2000000))});
    readback_all();
    idle_pct = 15;
    push_random(150, 5);
    stall_armed = 1'b1;
    wait_idle();

    // zero gain, largest threshold
    apb_write(REG_ACCEL_GAIN, 32'd0);
    apb_write(REG_TAP_THRESHOLD, 32'h00FF_FFFF);
    apb_write(REG_STEP_TIME, 32'($urandom_range(7, 65536)));
    readback_all();
    idle_pct = 40;
    push_random(20, 10);
    wait_idle();

    // back to reset settings, full rate on both sides
    apb_write(REG_STEP_TIME, 32'(STEP_TIME_RST));
    apb_write(REG_ACCEL_GAIN, 32'(ACCEL_GAIN_RST));
    apb_write(REG_TAP_THRESHOLD, 32'(TAP_THRESHOLD_RST));
    readback_all();
    idle_pct = 0;
    push_random(130, 4);
    wait_idle();

    if (n_errors == 0 && motion_queue.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
